// ===== hdl/b2da_pkg.sv =====
package b2da_pkg;

    // Width of the value field at the ports; only its low bits take part.
    localparam int unsigned INPUT_W             = 32;
    localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

    // Ten decimal digits cover every 32-bit value.
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned IDX_W   = $clog2(DIGITS);

    localparam int unsigned CHAR_W     = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [DIGITS-1:0] bcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } b2da_state_t;

    // Status of the shift-and-add-three converter towards the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

endpackage

// ===== hdl/b2da_dabble.sv =====
module b2da_dabble
    import b2da_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [INPUT_W-1:0]  value,
    output dab_status_t         status,
    output bcd_t                bcd
);

    localparam int unsigned EFF_W = (VALUE_WIDTH < INPUT_W) ? VALUE_WIDTH : INPUT_W;
    localparam int unsigned CNT_W = $clog2(EFF_W + 1);

    logic [EFF_W-1:0] shift_reg, shift_next;
    bcd_t             bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    bcd_t             adj;
    logic [DIGITS*DIGIT_W-1:0] adj_bits;

    // Every digit of five or more is corrected by three before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= digit_t'(5)) ? bcd_reg[i] + digit_t'(3) : bcd_reg[i];
        end
    end

    // Flat view of the corrected digits, so that the shift moves single bits.
    assign adj_bits = adj;

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = value[EFF_W-1:0];
            bcd_next   = '0;
            cnt_next   = CNT_W'(EFF_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adj_bits[DIGITS*DIGIT_W-2:0], shift_reg[EFF_W-1]};
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// ===== hdl/binary_to_decimal_ascii_top.sv =====
// Converts an unsigned binary value into decimal ASCII text, most significant
// digit first, one output transaction per digit. Leading zeros are dropped, so
// zero yields the single character '0', and the final (least significant)
// digit carries last_digit. Only the low VALUE_WIDTH bits of value are used
// (at most 32). One input transaction is handled at a time: after it is
// accepted, a shift-and-add-three converter takes one input bit per cycle
// over VALUE_WIDTH bits (capped at 32) and then flags completion; the
// digits then leave at one per cycle while the consumer keeps ready high, and
// the sequencer returns to idle as the final digit is loaded. The output
// register lets the final digit wait for the consumer while the next input
// transaction is already accepted.
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [INPUT_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    b2da_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] digit_char_reg, digit_char_next;
    logic              last_digit_reg, last_digit_next;

    logic              start;
    logic              load;
    logic [IDX_W-1:0]  msd_idx;
    dab_status_t       dab_status;
    bcd_t              bcd;

    // The converter holds the digit store; it only restarts from idle, so the
    // digits stay put while they are emitted.
    b2da_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .status (dab_status),
        .bcd    (bcd)
    );

    // Position of the most significant non-zero digit; zero when all digits
    // are zero, which gives the lone '0' for a zero input.
    always_comb
    begin
        msd_idx = '0;
        for (int i = 1; i < DIGITS; i++)
        begin
            if (bcd[i] != '0)
            begin
                msd_idx = IDX_W'(i);
            end
        end
    end

    // The output register may take a new digit when empty or being drained.
    assign load = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (dab_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load && (idx_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        start           = 1'b0;
        in_ready        = 1'b0;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        digit_char_next = digit_char_reg;
        last_digit_next = last_digit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                start    = in_valid;
            end
            ST_CONVERT:
            begin
                if (dab_status.done)
                begin
                    idx_next = msd_idx;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd[idx_reg]};
                    last_digit_next = (idx_reg == '0);
                    idx_next        = idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_char_reg <= digit_char_next;
        last_digit_reg <= last_digit_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

    // An accepted value must find the converter free and start it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !dab_status.busy)
        else $error("input accepted while converter busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONVERT && dab_status.busy))
        else $error("accepted value did not start a conversion");

    // Completion is only reported while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        dab_status.done |-> (state_reg == ST_CONVERT))
        else $error("conversion completed outside convert state");

    // A pending digit that is not the final one means more digits follow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_digit_reg) |-> (state_reg == ST_EMIT))
        else $error("digit run ended without a final digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg < IDX_W'(DIGITS)))
        else $error("digit index out of range");

endmodule

// ===== bench/tb.sv =====
// Testbench for binary_to_decimal_ascii_top.
//
// Every input transaction carries one unsigned 32-bit value. The block answers
// with the decimal text of that value, one output transaction per character,
// most significant digit first, and flags the final character with
// last_digit. The bench keeps its own model of that conversion: when a value
// is accepted, the characters it must produce are appended to a queue, and
// every output transaction is compared, field by field, with the oldest entry
// of that queue.
//
// The run is built from a handful of test tasks called in turn:
//   - directed values: zero, some single digits, several boundaries between
//     digit counts, the all-ones value and alternating bit patterns;
//   - random values, spread evenly over the number of decimal digits so that
//     short and long texts are equally common, with a share of fully random
//     32-bit words to toggle every input bit;
//   - a long hold-off on the output side while the sender keeps offering
//     values, so that the output register fills and the input stalls;
//   - a pause on the input side until every expected character has arrived.
//
// Both sides idle at random, mostly briefly and now and then for much
// longer, with stretches of no idling at all. A watchdog ends the run if
// no transaction is accepted on either side for a long time.
module tb
    import b2da_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The bench follows the default configuration of the block.
    localparam int unsigned TB_VALUE_WIDTH = VALUE_WIDTH_DEFAULT;

    // Number of random values in the main random test.
    localparam int unsigned RANDOM_VALUES = 70;

    // Length of the deliberate hold-off on the output side, in cycles.
    localparam int unsigned LONG_HOLD = 300;

    // Cycles without any accepted transaction before the run is abandoned.
    // The slowest legal stretch is the long hold-off above, well below this.
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // Cycles to wait after the last expected character, to catch strays.
    localparam int unsigned DRAIN_CYCLES = 60;

    // One expected output transaction.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } ascii_digit_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [INPUT_W-1:0] value      = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;

    // Characters still owed by the block, oldest first.
    ascii_digit_t pending_digits[$];

    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // When set, the sender offers values back to back with no gaps.
    bit tx_steady = 1'b0;

    // A non-zero value asks the receiver to hold out_ready low for that many
    // cycles; the receiver clears it once the hold-off is over.
    int unsigned hold_request = 0;

    binary_to_decimal_ascii_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Gap length for either side: mostly none or short, occasionally long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Works out the decimal text of one accepted value and queues it. Only the
    // low TB_VALUE_WIDTH bits take part. The digits are found least
    // significant first by repeated division by ten, then queued in reverse so
    // that the most significant digit leaves first.
    function automatic void predict_decimal_text(input logic [INPUT_W-1:0] number);
        logic [63:0]        width_mask;
        logic [INPUT_W-1:0] remaining;
        logic [DIGIT_W-1:0] digits [DIGITS];
        int unsigned        count;
        ascii_digit_t       entry;
        width_mask = (TB_VALUE_WIDTH >= 64) ? '1 : ((64'd1 << TB_VALUE_WIDTH) - 64'd1);
        remaining  = number & width_mask[INPUT_W-1:0];
        count      = 0;
        do
        begin
            digits[count] = DIGIT_W'(remaining % 10);
            count++;
            remaining = remaining / 10;
        end
        while (remaining != 0);
        for (int k = 0; k < count; k++)
        begin
            entry.ch   = ASCII_ZERO + CHAR_W'(digits[count - 1 - k]);
            entry.last = (k == count - 1);
            pending_digits.push_back(entry);
        end
    endfunction

    // Offers one value and returns at the edge where it is accepted. in_valid
    // is left high so that a following value can be offered without a gap;
    // stop_sending must be called before the caller lets time pass otherwise.
    task automatic send_value(input logic [INPUT_W-1:0] number);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            // Scribble on the data lines while idle; the block must ignore it.
            in_valid <= 1'b0;
            value    <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= number;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_decimal_text(number);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // A value with a chosen number of decimal digits, or a raw random word.
    function automatic logic [INPUT_W-1:0] random_value();
        int unsigned   width_digits;
        longint unsigned lowest;
        longint unsigned highest;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        width_digits = $urandom_range(1, DIGITS);
        lowest = 1;
        for (int i = 1; i < width_digits; i++)
            lowest = lowest * 10;
        highest = lowest * 10 - 1;
        if (width_digits == 1)
            lowest = 0;
        if (highest > 64'hFFFF_FFFF)
            highest = 64'hFFFF_FFFF;
        return $urandom_range(INPUT_W'(highest), INPUT_W'(lowest));
    endfunction

    // Zero, some single digits, several boundaries where the number of digits
    // changes, the largest value and alternating bit patterns.
    task automatic test_directed_values();
        logic [INPUT_W-1:0] corner_values [] = '{
            32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100,
            32'd999, 32'd1000, 32'd65535, 32'd65536, 32'd999999999,
            32'd1000000000, 32'd1000000001, 32'd1234567890, 32'd2147483647,
            32'd2147483648, 32'd4294967294, 32'd4294967295,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        foreach (corner_values[i])
            send_value(corner_values[i]);
        stop_sending();
    endtask

    // Random values in bursts of ten; every other burst has no gaps at all.
    task automatic test_random_values();
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            tx_steady = ((i / 10) % 2) == 1;
            send_value(random_value());
        end
        tx_steady = 1'b0;
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while values keep coming in
    // back to back. Once a digit waits behind a full output register, in_ready
    // stays low until the receiver resumes.
    task automatic test_output_hold_off();
        hold_request <= LONG_HOLD;
        tx_steady = 1'b1;
        for (int i = 0; i < 4; i++)
            send_value(random_value());
        tx_steady = 1'b0;
        stop_sending();
        wait_for_drain();
    endtask

    // The sender pauses until every expected character has arrived, then
    // carries on, so that the block is restarted from a fully idle state.
    task automatic test_pause_until_empty();
        for (int round = 0; round < 3; round++)
        begin
            send_value(random_value());
            send_value(random_value());
            stop_sending();
            wait_for_drain();
        end
    endtask

    // Receiver: alternates between stretches of steady acceptance and
    // stretches of random stalls, and serves the long hold-off on request.
    initial
    begin
        int unsigned stretch_left;
        int unsigned stall_left;
        bit          steady;
        stretch_left = 0;
        stall_left   = 0;
        steady       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request <= 0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    steady       = ($urandom_range(0, 3) == 0);
                    stretch_left = $urandom_range(30, 200);
                end
                stretch_left--;
                if (stall_left != 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if (!steady && $urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Checker: each accepted output transaction is compared with the oldest
    // expected character. An unexpected character counts as a failure too.
    always @(posedge clk)
    begin
        ascii_digit_t expected;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected character: digit_char %0d last_digit %0b",
                         $time, digit_char, last_digit);
            end
            else
            begin
                expected = pending_digits.pop_front();
                if (digit_char !== expected.ch)
                begin
                    mismatches++;
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, expected.ch, digit_char);
                end
                if (last_digit !== expected.last)
                begin
                    mismatches++;
                    $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                             $time, expected.last, last_digit);
                end
            end
        end
    end

    // Watchdog: counts consecutive clocks on which neither side accepts a
    // transaction and abandons the run when that count reaches its limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset once, run the tests in turn, then let the block
    // settle and report.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values();
        test_output_hold_off();
        test_pause_until_empty();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
